@@ sv/fmf_pkg.sv @@
// Shared types, constants and helpers for the face mass flux block.
// No dependencies; every other file imports this package.
`default_nettype none
package fmf_pkg;

  localparam int CELL_COUNT = 1024;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int IDX_W      = 10;
  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int DENS_W     = 31;
  localparam int MUL_W      = WORD_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int WIDE_W     = 50;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 50'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -50'sd2147483648;
  localparam logic [DENS_W-1:0] DENSITY_RESET = 31'd65536;

  typedef enum logic [2:0] {
    KIND_INTERIOR       = 3'd0,
    KIND_FIXED_VALUE    = 3'd1,
    KIND_FIXED_GRADIENT = 3'd2,
    KIND_ZERO_GRADIENT  = 3'd3,
    KIND_NO_SLIP        = 3'd4,
    KIND_LOAD           = 3'd5
  } kind_t;

  // x in [0], y in [1], z in [2]
  typedef logic [2:0][WORD_W-1:0] vec3_t;

  typedef struct packed {
    vec3_t cent;
    vec3_t vel;
  } cell_data_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    cell_data_t         wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } store_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val  = SAT_MAX[WORD_W-1:0];
      r.clip = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val  = SAT_MIN[WORD_W-1:0];
      r.clip = 1'b1;
    end else begin
      r.val  = v[WORD_W-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sext(input logic [WORD_W-1:0] v);
    return $signed({{(WIDE_W-WORD_W){v[WORD_W-1]}}, v});
  endfunction

endpackage
`default_nettype wire

@@ sv/fmf_if.sv @@
// Channel interfaces: input item, result word and density write.
// Depends on fmf_pkg.
`default_nettype none
interface fmf_in_if;
  import fmf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               item_kind;
  logic [IDX_W-1:0]         cell_index;
  logic [IDX_W-1:0]         neighbour_index;
  logic signed [WORD_W-1:0] vec_a_x;
  logic signed [WORD_W-1:0] vec_a_y;
  logic signed [WORD_W-1:0] vec_a_z;
  logic signed [WORD_W-1:0] vec_b_x;
  logic signed [WORD_W-1:0] vec_b_y;
  logic signed [WORD_W-1:0] vec_b_z;
  logic signed [WORD_W-1:0] bc_x;
  logic signed [WORD_W-1:0] bc_y;
  logic signed [WORD_W-1:0] bc_z;
  modport source(output valid, item_kind, cell_index, neighbour_index, vec_a_x, vec_a_y,
                 vec_a_z, vec_b_x, vec_b_y, vec_b_z, bc_x, bc_y, bc_z, input ready);
  modport sink(input valid, item_kind, cell_index, neighbour_index, vec_a_x, vec_a_y,
               vec_a_z, vec_b_x, vec_b_y, vec_b_z, bc_x, bc_y, bc_z, output ready);
endinterface

interface fmf_out_if;
  import fmf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] mass_flux;
  logic                     saturated;
  logic                     zero_distance;
  modport source(output valid, mass_flux, saturated, zero_distance, input ready);
  modport sink(input valid, mass_flux, saturated, zero_distance, output ready);
endinterface

interface fmf_cfg_if;
  import fmf_pkg::*;
  logic              valid;
  logic              ready;
  logic [DENS_W-1:0] density;
  modport source(output valid, density, input ready);
  modport sink(input valid, density, output ready);
endinterface
`default_nettype wire

@@ sv/fmf_cell_store.sv @@
// Cell store: centroid and velocity memories, one write and one read port each.
// Depends on fmf_pkg. Read data is registered and appears in the cycle after the read request.
`default_nettype none
module fmf_cell_store (
  input  wire                  clk,
  input  wire fmf_pkg::store_req_t req,
  output fmf_pkg::cell_data_t  rdata
);
  import fmf_pkg::*;

  vec3_t cent_mem [CELL_COUNT];
  vec3_t vel_mem  [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      cent_mem[req.waddr] <= req.wdata.cent;
      vel_mem[req.waddr]  <= req.wdata.vel;
    end
    if (req.re) begin
      rdata.cent <= cent_mem[req.raddr];
      rdata.vel  <= vel_mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/face_mass_flux.sv @@
// Face mass flux top level: sequencer, shared multiplier, square root and divider.
// Depends on fmf_pkg, fmf_if and fmf_cell_store.
//
//   channel  dir  handshake        word
//   in_ch    in   valid/ready      kind, cell indexes, area, centroid, bc
//   out_ch   out  valid/ready      mass_flux, saturated, zero_distance
//   cfg_ch   in   valid/ready      density (ready high out of reset)
//
// One item at a time. The bit-serial square root, the 17-step divider and the
// one shared 33x33 multiplier set how long each face kind takes.
// Reset is synchronous; the cell store needs no clearing. A result waits in
// the output register; the next item is taken while it waits.
`default_nettype none
module face_mass_flux (
  input  wire          clk,
  input  wire          rst_n,
  fmf_in_if.sink       in_ch,
  fmf_out_if.source    out_ch,
  fmf_cfg_if.sink      cfg_ch
);
  import fmf_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDP   = 13'b0000000000010,
    S_RDN   = 13'b0000000000100,
    S_CAPN  = 13'b0000000001000,
    S_DIFF  = 13'b0000000010000,
    S_SQ    = 13'b0000000100000,
    S_SQRT  = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_BLEND = 13'b0000100000000,
    S_GRAD  = 13'b0001000000000,
    S_DOT   = 13'b0010000000000,
    S_FLUX  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  state_t            state_r, state_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              out_valid_r;
  logic [DENS_W-1:0] density_r;

  logic [2:0]          kind_r;
  logic [CELL_AW-1:0]  p_r, n_r;
  vec3_t               sf_r, fc_r, bc_r, up_r, un_r, cp_r, cn_r, uf_r, dabs_r;
  logic                second_r, sat_r, zd_r;
  logic [63:0]         sq_x_r, sq_res_r, sq_bit_r;
  logic [WORD_W-1:0]   dp_r, mag_r;
  logic [33:0]         div_r;
  logic [32:0]         den_r;
  logic [FRAC_BITS:0]  q_r;
  logic signed [WIDE_W-1:0] tmp_r, dot_acc_r;
  logic signed [WORD_W-1:0] dot32_r, flux_r;
  logic signed [WORD_W-1:0] out_flux_r;
  logic                out_sat_r, out_zd_r;
  logic signed [PROD_W-1:0] prod_r;

  store_req_t st_req;
  cell_data_t st_rdata;

  logic in_fire, out_load, is_int, is_grad;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign cfg_ch.ready = rst_n;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign is_int   = (kind_r == KIND_INTERIOR);
  assign is_grad  = (kind_r == KIND_FIXED_GRADIENT);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mass_flux     = out_flux_r;
  assign out_ch.saturated     = out_sat_r;
  assign out_ch.zero_distance = out_zd_r;

  // cell store
  always_comb begin
    st_req.we            = in_fire && (in_ch.item_kind == KIND_LOAD);
    st_req.waddr         = in_ch.cell_index[CELL_AW-1:0];
    st_req.wdata.cent    = {in_ch.vec_a_z, in_ch.vec_a_y, in_ch.vec_a_x};
    st_req.wdata.vel     = {in_ch.vec_b_z, in_ch.vec_b_y, in_ch.vec_b_x};
    st_req.re            = (state_r == S_RDP) || (state_r == S_RDN);
    st_req.raddr         = (state_r == S_RDP) ? p_r : n_r;
  end

  fmf_cell_store u_store (
    .clk   (clk),
    .req   (st_req),
    .rdata (st_rdata)
  );

  // shared multiplier operands
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic [FRAC_BITS:0]      omw;
  assign omw = ONE_Q - q_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SQ: begin
        mul_a = $signed({1'b0, dabs_r[0]});
        mul_b = $signed({1'b0, dabs_r[0]});
      end
      S_BLEND: begin
        if (!cnt_r[0]) begin
          mul_a = $signed({up_r[0][WORD_W-1], up_r[0]});
          mul_b = $signed({{(MUL_W-FRAC_BITS-1){1'b0}}, omw});
        end else begin
          mul_a = $signed({un_r[0][WORD_W-1], un_r[0]});
          mul_b = $signed({{(MUL_W-FRAC_BITS-1){1'b0}}, q_r});
        end
      end
      S_GRAD: begin
        mul_a = $signed({bc_r[0][WORD_W-1], bc_r[0]});
        mul_b = $signed({1'b0, mag_r});
      end
      S_DOT: begin
        mul_a = $signed({uf_r[0][WORD_W-1], uf_r[0]});
        mul_b = $signed({sf_r[0][WORD_W-1], sf_r[0]});
      end
      S_FLUX: begin
        mul_a = $signed({dot32_r[WORD_W-1], dot32_r});
        mul_b = $signed({{(MUL_W-DENS_W){1'b0}}, density_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  logic signed [PROD_W-1:0] prod_shr;
  logic signed [WIDE_W-1:0] prod_sh;
  logic signed [WIDE_W-1:0] prod_lo;
  assign prod_shr = prod_r >>> FRAC_BITS;
  assign prod_sh  = prod_shr[WIDE_W-1:0];
  assign prod_lo  = prod_r[WIDE_W-1:0];

  // face centroid minus cell centroid, clipped, magnitude per component
  vec3_t dabs_nxt;
  logic  diff_clip;
  always_comb begin
    vec3_t c_sel;
    logic signed [WIDE_W-1:0] d;
    sat_t s;
    c_sel = second_r ? cn_r : cp_r;
    diff_clip = 1'b0;
    for (int j = 0; j < 3; j++) begin
      d = sext(fc_r[j]) - sext(c_sel[j]);
      s = sat32(d);
      diff_clip = diff_clip | s.clip;
      dabs_nxt[j] = s.val[WORD_W-1] ? (~s.val + 1'b1) : s.val;
    end
  end

  // one square root step per cycle
  logic [63:0] sq_sum, sq_x_nxt, sq_res_nxt;
  logic        sq_ge;
  logic [32:0] den_sum;
  assign sq_sum     = sq_res_r + sq_bit_r;
  assign sq_ge      = sq_x_r >= sq_sum;
  assign sq_x_nxt   = sq_ge ? (sq_x_r - sq_sum) : sq_x_r;
  assign sq_res_nxt = sq_ge ? ((sq_res_r >> 1) + sq_bit_r) : (sq_res_r >> 1);
  assign den_sum    = {1'b0, dp_r} + {1'b0, sq_res_nxt[WORD_W-1:0]};

  // one quotient bit per cycle
  logic [33:0] div_rr;
  logic        div_ge;
  assign div_rr = (cnt_r == '0) ? div_r : (div_r << 1);
  assign div_ge = div_rr >= {1'b0, den_r};

  // gradient and blend results, dot and flux clipping
  sat_t grad_s, dot_s, flux_s;
  logic signed [WIDE_W-1:0] blend_sum, dot_tot;
  assign grad_s    = sat32(sext(up_r[0]) + prod_sh);
  // sum both full products, then drop the fraction once
  assign blend_sum = (tmp_r + prod_lo) >>> FRAC_BITS;
  assign dot_tot   = dot_acc_r + prod_sh;
  assign dot_s     = sat32(dot_tot);
  assign flux_s    = sat32(prod_sh);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.item_kind != KIND_LOAD)) state_nxt = S_RDP;
      end
      S_RDP: state_nxt = S_RDN;
      S_RDN: state_nxt = S_CAPN;
      S_CAPN: begin
        state_nxt = (is_int || is_grad) ? S_DIFF : S_DOT;
        cnt_nxt   = '0;
      end
      S_DIFF: begin
        state_nxt = S_SQ;
        cnt_nxt   = '0;
      end
      S_SQ: begin
        if (cnt_r == 6'd3) begin
          state_nxt = S_SQRT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SQRT: begin
        if (cnt_r == 6'd31) begin
          cnt_nxt = '0;
          priority if (is_int && !second_r) state_nxt = S_DIFF;
          else if (is_int) state_nxt = (den_sum == '0) ? S_BLEND : S_DIV;
          else state_nxt = S_GRAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        if (cnt_r == 6'(FRAC_BITS)) begin
          state_nxt = S_BLEND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_BLEND: begin
        if (cnt_r == 6'd6) begin
          state_nxt = S_DOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GRAD: begin
        if (cnt_r == 6'd3) begin
          state_nxt = S_DOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DOT: begin
        if (cnt_r == 6'd3) begin
          state_nxt = S_FLUX;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FLUX: begin
        if (cnt_r == 6'd1) begin
          state_nxt = S_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      density_r   <= DENSITY_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        density_r <= cfg_ch.density;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          kind_r   <= in_ch.item_kind;
          p_r      <= in_ch.cell_index[CELL_AW-1:0];
          n_r      <= in_ch.neighbour_index[CELL_AW-1:0];
          sf_r     <= {in_ch.vec_a_z, in_ch.vec_a_y, in_ch.vec_a_x};
          fc_r     <= {in_ch.vec_b_z, in_ch.vec_b_y, in_ch.vec_b_x};
          bc_r     <= {in_ch.bc_z, in_ch.bc_y, in_ch.bc_x};
          second_r <= 1'b0;
          sat_r    <= 1'b0;
          zd_r     <= 1'b0;
        end
      end
      S_RDP: begin
      end
      S_RDN: begin
        cp_r <= st_rdata.cent;
        up_r <= st_rdata.vel;
      end
      S_CAPN: begin
        cn_r <= st_rdata.cent;
        un_r <= st_rdata.vel;
        priority if (kind_r == KIND_FIXED_VALUE) uf_r <= bc_r;
        else if (kind_r == KIND_NO_SLIP) uf_r <= '0;
        else uf_r <= up_r;
      end
      S_DIFF: begin
        dabs_r <= dabs_nxt;
        sat_r  <= sat_r | diff_clip;
        sq_x_r <= '0;
      end
      S_SQ: begin
        if (cnt_r != 6'd3) dabs_r <= {dabs_r[0], dabs_r[2:1]};
        if (cnt_r != '0) sq_x_r <= sq_x_r + prod_r[63:0];
        if (cnt_r == 6'd3) begin
          sq_res_r <= '0;
          sq_bit_r <= 64'd1 << 62;
        end
      end
      S_SQRT: begin
        sq_x_r   <= sq_x_nxt;
        sq_res_r <= sq_res_nxt;
        sq_bit_r <= sq_bit_r >> 2;
        if (cnt_r == 6'd31) begin
          priority if (is_int && !second_r) begin
            dp_r     <= sq_res_nxt[WORD_W-1:0];
            second_r <= 1'b1;
          end else if (is_int) begin
            div_r <= {2'b00, dp_r};
            den_r <= den_sum;
            q_r   <= '0;
            if (den_sum == '0) zd_r <= 1'b1;
          end else begin
            mag_r <= sq_res_nxt[WORD_W-1:0];
          end
        end
      end
      S_DIV: begin
        div_r <= div_ge ? (div_rr - {1'b0, den_r}) : div_rr;
        q_r   <= {q_r[FRAC_BITS-1:0], div_ge};
      end
      S_BLEND: begin
        if (cnt_r != 6'd6) begin
          if (!cnt_r[0]) up_r <= {up_r[0], up_r[2:1]};
          else un_r <= {un_r[0], un_r[2:1]};
        end
        if (cnt_r != '0) begin
          if (cnt_r[0]) tmp_r <= prod_lo;
          else uf_r <= {blend_sum[WORD_W-1:0], uf_r[2:1]};
        end
      end
      S_GRAD: begin
        if (cnt_r != 6'd3) bc_r <= {bc_r[0], bc_r[2:1]};
        if (cnt_r != '0) begin
          uf_r  <= {grad_s.val, uf_r[2:1]};
          up_r  <= {up_r[0], up_r[2:1]};
          sat_r <= sat_r | grad_s.clip;
        end
      end
      S_DOT: begin
        if (cnt_r != 6'd3) begin
          uf_r <= {uf_r[0], uf_r[2:1]};
          sf_r <= {sf_r[0], sf_r[2:1]};
        end
        if (cnt_r == '0) begin
          dot_acc_r <= '0;
        end else if (cnt_r != 6'd3) begin
          dot_acc_r <= dot_tot;
        end else begin
          dot32_r <= dot_s.val;
          sat_r   <= sat_r | dot_s.clip;
        end
      end
      S_FLUX: begin
        if (cnt_r == 6'd1) begin
          flux_r <= flux_s.val;
          sat_r  <= sat_r | flux_s.clip;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_flux_r <= flux_r;
          out_sat_r  <= sat_r;
          out_zd_r   <= zd_r;
        end
      end
      default: begin
      end
    endcase
  end

  // checks
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word raised outside the done step");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.we |-> state_r == S_IDLE)
    else $error("cell store written while a face is in work");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> den_r != '0)
    else $error("divider running on a zero distance sum");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_ch.ready |=> state_r == S_DONE)
    else $error("finished face dropped while the output word is stalled");

endmodule
`default_nettype wire

@@ test/face_mass_flux_tb.sv @@
// Testbench for face_mass_flux: loads cells, sends random and directed faces,
// and compares each flux word against an in-bench fixed-point predictor.
// Depends on fmf_pkg, fmf_if and the face_mass_flux RTL.
`default_nettype none
module face_mass_flux_tb;
  import fmf_pkg::*;

  typedef struct packed {
    logic [2:0]        kind;
    logic [IDX_W-1:0]  p;
    logic [IDX_W-1:0]  n;
    logic [2:0][31:0]  a;
    logic [2:0][31:0]  b;
    logic [2:0][31:0]  bc;
  } face_word_t;

  typedef struct packed {
    logic [31:0] flux;
    logic        sat;
    logic        zd;
  } flux_word_t;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  fmf_in_if in_ch();
  fmf_out_if out_ch();
  fmf_cfg_if cfg_ch();

  face_mass_flux dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                      .cfg_ch(cfg_ch));

  initial forever #5 clk = ~clk;

  face_word_t pending_faces[$];
  flux_word_t expected_fluxes[$];
  logic [31:0] cent_mem[CELL_COUNT][3];
  logic [31:0] vel_mem[CELL_COUNT][3];
  bit written[CELL_COUNT];
  int written_list[$];
  logic [30:0] density_q = DENSITY_RESET;
  int errors = 0;
  int idle_pct = 26;
  int hold_off = 0;
  int idle_cycles = 0;

  function automatic longint sat_word(longint v, ref bit flag);
    if (v > 64'sd2147483647) begin flag = 1; return 64'sd2147483647; end
    if (v < -64'sd2147483648) begin flag = 1; return -64'sd2147483648; end
    return v;
  endfunction

  // floor shift; arithmetic shift floors already
  function automatic longint floor_q(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else res >>= 1;
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint cell_distance(face_word_t f, int c, ref bit flag);
    longint d;
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      d = sat_word(longint'($signed(f.b[i])) - longint'($signed(cent_mem[c][i])), flag);
      if (d < 0) d = -d;
      sum += longint'(d) * longint'(d);
    end
    return int_sqrt(sum);
  endfunction

  function automatic flux_word_t face_flux(face_word_t f);
    flux_word_t r;
    bit sat, zd;
    longint uf[3], up[3], un[3];
    longint dp, dn, w, mag, dot;
    sat = 0;
    zd = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) up[i] = $signed(vel_mem[f.p][i]);
    case (f.kind)
      KIND_INTERIOR: begin
        dp = cell_distance(f, f.p, sat);
        dn = cell_distance(f, f.n, sat);
        w = 0;
        if (dp + dn == 0) zd = 1;
        else w = (dp << FRAC_BITS) / (dp + dn);
        for (int i = 0; i < 3; i++) begin
          un[i] = $signed(vel_mem[f.n][i]);
          uf[i] = floor_q(up[i] * ((64'sd1 << FRAC_BITS) - w) + un[i] * w);
        end
      end
      KIND_FIXED_VALUE: for (int i = 0; i < 3; i++) uf[i] = $signed(f.bc[i]);
      KIND_FIXED_GRADIENT: begin
        mag = cell_distance(f, f.p, sat);
        for (int i = 0; i < 3; i++)
          uf[i] = sat_word(up[i] + floor_q(longint'($signed(f.bc[i])) * mag), sat);
      end
      KIND_NO_SLIP: for (int i = 0; i < 3; i++) uf[i] = 0;
      default: for (int i = 0; i < 3; i++) uf[i] = up[i];
    endcase
    for (int i = 0; i < 3; i++) dot += floor_q(uf[i] * longint'($signed(f.a[i])));
    dot = sat_word(dot, sat);
    r.flux = 32'(sat_word(floor_q(dot * longint'(density_q)), sat));
    r.sat = sat;
    r.zd = zd;
    return r;
  endfunction

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
      2: return 32'($signed($urandom_range(0, 32'h03ff_ffff)) - 32'sh2000000);
      default: return $urandom_range(0, 3) == 0 ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 99);
    return r < 10 ? 0 : r < 65 ? 1 : r < 92 ? 2 : 3;
  endfunction

  function automatic int pick_cell();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  task automatic push_load(int c, int m);
    face_word_t f;
    f.kind = KIND_LOAD;
    f.p = IDX_W'(c);
    f.n = IDX_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      f.a[i] = rand_word(m);
      f.b[i] = rand_word(m);
      f.bc[i] = $urandom;
    end
    pending_faces.push_back(f);
    if (!written[c]) begin written[c] = 1; written_list.push_back(c); end
  endtask

  task automatic push_face(logic [2:0] kind);
    face_word_t f;
    int m;
    m = pick_mode();
    f.kind = kind;
    f.p = IDX_W'(pick_cell());
    f.n = kind == KIND_INTERIOR ? IDX_W'(pick_cell()) : IDX_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      f.a[i] = rand_word(m);
      f.b[i] = rand_word(pick_mode());
      f.bc[i] = rand_word(pick_mode());
    end
    pending_faces.push_back(f);
  endtask

  task automatic drain();
    while (pending_faces.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_fluxes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_density(logic [30:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.density <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    density_q = d;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        face_word_t f;
        f = {in_ch.item_kind, in_ch.cell_index, in_ch.neighbour_index,
             in_ch.vec_a_z, in_ch.vec_a_y, in_ch.vec_a_x,
             in_ch.vec_b_z, in_ch.vec_b_y, in_ch.vec_b_x,
             in_ch.bc_z, in_ch.bc_y, in_ch.bc_x};
        if (f.kind == KIND_LOAD) begin
          for (int i = 0; i < 3; i++) begin
            cent_mem[f.p][i] = f.a[i];
            vel_mem[f.p][i] = f.b[i];
          end
        end else expected_fluxes.push_back(face_flux(f));
      end
      if ((!in_ch.valid || in_ch.ready) && pending_faces.size() != 0 &&
          $urandom_range(0, 99) >= idle_pct) begin
        face_word_t f;
        f = pending_faces.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.item_kind <= f.kind;
        in_ch.cell_index <= f.p;
        in_ch.neighbour_index <= f.n;
        {in_ch.vec_a_z, in_ch.vec_a_y, in_ch.vec_a_x} <= f.a;
        {in_ch.vec_b_z, in_ch.vec_b_y, in_ch.vec_b_x} <= f.b;
        {in_ch.bc_z, in_ch.bc_y, in_ch.bc_x} <= f.bc;
      end else if (in_ch.ready) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        flux_word_t got, want;
        got = {out_ch.mass_flux, out_ch.saturated, out_ch.zero_distance};
        if (expected_fluxes.size() == 0) begin
          $display("%0t: unexpected word flux=%h sat=%b zd=%b", $time,
                   got.flux, got.sat, got.zd);
          errors++;
        end else begin
          want = expected_fluxes.pop_front();
          if (got.flux !== want.flux) begin
            $display("%0t: mass_flux expected %h actual %h", $time, want.flux, got.flux);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
          end
          if (got.zd !== want.zd) begin
            $display("%0t: zero_distance expected %b actual %b", $time, want.zd, got.zd);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(0, 99) >= idle_pct;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (pending_faces.size() == 0 && expected_fluxes.size() == 0 && !in_ch.valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    face_word_t f;
    logic [2:0] kind;
    in_ch.valid = 1'b0;
    in_ch.item_kind = '0;
    in_ch.cell_index = '0;
    in_ch.neighbour_index = '0;
    {in_ch.vec_a_x, in_ch.vec_a_y, in_ch.vec_a_z} = '0;
    {in_ch.vec_b_x, in_ch.vec_b_y, in_ch.vec_b_z} = '0;
    {in_ch.bc_x, in_ch.bc_y, in_ch.bc_z} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.density = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme cells, coincident centroids, every kind
    push_load(0, 1);
    push_load(1023, 3);
    push_load(5, 1);
    f = '0;
    f.kind = KIND_LOAD;
    f.p = 6;
    f.b = {32'h0001_0000, 32'hffff_0000, 32'h0002_0000};
    pending_faces.push_back(f);
    written[6] = 1;
    written_list.push_back(6);
    f.p = 7;
    f.b = {32'h8000_0000, 32'h7fff_ffff, 32'h0000_8000};
    pending_faces.push_back(f);
    written[7] = 1;
    written_list.push_back(7);
    f.kind = KIND_INTERIOR;
    f.p = 6;
    f.n = 7;
    f.a = {3{32'h0001_0000}};
    f.b = '0;
    pending_faces.push_back(f);
    f.a = {3{32'h7fff_ffff}};
    pending_faces.push_back(f);
    f.a = {3{32'h8000_0000}};
    f.bc = {3{32'h7fff_ffff}};
    for (int k = 0; k < 8; k++) begin
      f.kind = 3'(k);
      f.p = 1023;
      f.n = 0;
      f.b = {3{32'h8000_0000}};
      if (k != KIND_LOAD) pending_faces.push_back(f);
    end
    for (int k = 0; k < 8; k++)
      if (k != KIND_LOAD) push_face(3'(k));
    drain();
    write_density(31'h7fff_ffff);
    push_face(KIND_INTERIOR);
    push_face(KIND_FIXED_VALUE);
    push_face(KIND_FIXED_GRADIENT);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_density(31'd0);
        1: write_density(31'($urandom_range(0, 32'h0004_0000)));
        2: write_density(DENSITY_RESET);
        default: write_density(31'($urandom));
      endcase
      idle_pct = ph == 2 ? 0 : 26;
      for (int i = 0; i < 95; i++) begin
        if ($urandom_range(0, 99) < 20) push_load($urandom_range(0, 1023), pick_mode());
        else begin
          kind = $urandom_range(0, 99) < 45 ? KIND_INTERIOR : 3'($urandom_range(0, 7));
          if (kind == KIND_LOAD) kind = KIND_FIXED_GRADIENT;
          push_face(kind);
        end
      end
      if (ph == 1) hold_off = 3000;
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
